// ===== src/mm_pkg.sv =====
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 35;
  localparam int FUNC_W  = 2;
  localparam int CIDX_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CIDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CIDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Highest usable index for a size register: zero acts as one and
  // anything above the maximum acts as the maximum.
  function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    begin
      if (v == '0) begin
        d = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
        d = DIM_W'(MAX_DIM);
      end else begin
        d = v;
      end
      last_index = IDX_W'(d - DIM_W'(1));
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/mm_if.sv =====
`default_nettype none

interface mm_cmd_if;
  logic                               valid;
  logic                               ready;
  logic        [mm_pkg::FUNC_W-1:0]   func;
  logic        [mm_pkg::IDX_W-1:0]    row;
  logic        [mm_pkg::IDX_W-1:0]    col;
  logic signed [mm_pkg::VAL_W-1:0]    value;

  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mm_res_if;
  logic                               valid;
  logic                               ready;
  logic        [mm_pkg::IDX_W-1:0]    out_row;
  logic        [mm_pkg::IDX_W-1:0]    out_col;
  logic signed [mm_pkg::SUM_W-1:0]    sum;
  logic                               last;

  modport source (output valid, out_row, out_col, sum, last, input ready);
  modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

`default_nettype wire

// ===== src/matrix_multiply_unit.sv =====
`default_nettype none

// Matrix multiply unit. Words on the cmd channel either load one signed Q8.8
// element of A or B into its on-chip store, or start a product C = A * B.
// A load is dropped silently when its row or column lies outside the
// configured size. A compute word makes the unit walk the stores and return C
// in row-major order on the res channel, one word per entry, each an exact
// signed Q19.16 dot product with last set on the final entry. For each entry
// the two stores, each with a single registered read port, and one shared
// multiplier take in one product term per cycle; the terms drain through the
// read, product and accumulate registers, and the entry is handed to the
// output register once it is free, so a stalling sink holds up the walk.
// The unit accepts no new cmd word until the product is walked, but the last
// entry may still sit in the output register while the next word is taken.
// Size registers are written over the cfg port; the user must write them
// only while the unit is idle; the block does not enforce it. A value of
// zero acts as one and values above eight act as eight. Store entries have
// no reset value, so a product must only touch entries that were loaded.
module matrix_multiply_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mm_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]      cfg_data,
  mm_cmd_if.sink                             cmd,
  mm_res_if.source                           res
);

  // Size registers.
  logic [mm_pkg::DIM_W-1:0] rows_a;
  logic [mm_pkg::DIM_W-1:0] inner_dim;
  logic [mm_pkg::DIM_W-1:0] cols_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
      inner_dim <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
      cols_b    <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mm_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mm_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mm_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [mm_pkg::IDX_W-1:0] m_last;
  logic [mm_pkg::IDX_W-1:0] k_last;
  logic [mm_pkg::IDX_W-1:0] n_last;

  assign m_last = mm_pkg::last_index(rows_a);
  assign k_last = mm_pkg::last_index(inner_dim);
  assign n_last = mm_pkg::last_index(cols_b);

  // Control state.
  mm_pkg::state_t st;
  mm_pkg::state_t st_next;

  logic [mm_pkg::IDX_W-1:0] i_idx;
  logic [mm_pkg::IDX_W-1:0] j_idx;
  logic [mm_pkg::IDX_W-1:0] r_idx;
  logic                     acc_done;

  logic cmd_fire;
  logic load_a;
  logic load_b;
  logic start;
  logic issue;
  logic issue_last;
  logic out_free;
  logic emit;
  logic final_entry;

  assign cmd_fire    = cmd.valid && cmd.ready;
  assign out_free    = !res.valid || res.ready;
  assign final_entry = (i_idx == m_last) && (j_idx == n_last);
  assign issue_last  = issue && (r_idx == k_last);

  // Next-state logic.
  always_comb begin
    st_next = st;
    unique case (st)
      mm_pkg::ST_IDLE: begin
        if (start) begin
          st_next = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        if (r_idx == k_last) begin
          st_next = mm_pkg::ST_WAIT;
        end
      end
      mm_pkg::ST_WAIT: begin
        if (acc_done) begin
          st_next = mm_pkg::ST_EMIT;
        end
      end
      mm_pkg::ST_EMIT: begin
        if (out_free) begin
          st_next = final_entry ? mm_pkg::ST_IDLE : mm_pkg::ST_RUN;
        end
      end
      default: st_next = mm_pkg::ST_IDLE;
    endcase
  end

  // Decoded controls for the current state.
  always_comb begin
    cmd.ready = 1'b0;
    load_a    = 1'b0;
    load_b    = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    emit      = 1'b0;
    unique case (st)
      mm_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd_fire) begin
          unique case (cmd.func)
            mm_pkg::FUNC_LOAD_A:
              load_a = (cmd.row <= m_last) && (cmd.col <= k_last);
            mm_pkg::FUNC_LOAD_B:
              load_b = (cmd.row <= k_last) && (cmd.col <= n_last);
            mm_pkg::FUNC_COMPUTE:
              start = 1'b1;
            default: ;
          endcase
        end
      end
      mm_pkg::ST_RUN:  issue = 1'b1;
      mm_pkg::ST_WAIT: ;
      mm_pkg::ST_EMIT: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mm_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Row, column and term counters of the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx <= '0;
      j_idx <= '0;
      r_idx <= '0;
    end else if (start) begin
      i_idx <= '0;
      j_idx <= '0;
      r_idx <= '0;
    end else if (issue) begin
      if (r_idx != k_last) begin
        r_idx <= r_idx + 1'b1;
      end
    end else if (emit) begin
      r_idx <= '0;
      if (j_idx == n_last) begin
        j_idx <= '0;
        i_idx <= i_idx + 1'b1;
      end else begin
        j_idx <= j_idx + 1'b1;
      end
    end
  end

  // Element stores, one write and one registered read port each. Writes happen
  // only while idle and read data is used only while walking, so they never meet.
  logic [mm_pkg::VAL_W-1:0]  a_mem [mm_pkg::DEPTH];
  logic [mm_pkg::VAL_W-1:0]  b_mem [mm_pkg::DEPTH];
  logic [mm_pkg::ADDR_W-1:0] a_waddr;
  logic [mm_pkg::ADDR_W-1:0] b_waddr;
  logic [mm_pkg::ADDR_W-1:0] a_raddr;
  logic [mm_pkg::ADDR_W-1:0] b_raddr;
  logic [mm_pkg::VAL_W-1:0]  a_q;
  logic [mm_pkg::VAL_W-1:0]  b_q;

  assign a_waddr = {cmd.row, cmd.col};
  assign b_waddr = {cmd.row, cmd.col};
  assign a_raddr = {i_idx, r_idx};
  assign b_raddr = {r_idx, j_idx};

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_mem[a_waddr] <= cmd.value;
    end
    a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_mem[b_waddr] <= cmd.value;
    end
    b_q <= b_mem[b_raddr];
  end

  // Term pipeline: read, multiply, accumulate.
  logic                            rd_v;
  logic                            rd_last;
  logic                            prod_v;
  logic                            prod_last;
  logic signed [mm_pkg::PROD_W-1:0] prod;
  logic signed [mm_pkg::SUM_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
    end else begin
      rd_v      <= issue;
      rd_last   <= issue_last;
      prod_v    <= rd_v;
      prod_last <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_q) * $signed(b_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      acc_done <= 1'b0;
    end else if (emit || start) begin
      acc      <= '0;
      acc_done <= 1'b0;
    end else if (prod_v) begin
      acc <= acc + {{(mm_pkg::SUM_W - mm_pkg::PROD_W){prod[mm_pkg::PROD_W-1]}}, prod};
      if (prod_last) begin
        acc_done <= 1'b1;
      end
    end
  end

  // Output register; the walk can go on while a finished entry waits here.
  logic                            res_valid;
  logic [mm_pkg::IDX_W-1:0]        res_row;
  logic [mm_pkg::IDX_W-1:0]        res_col;
  logic signed [mm_pkg::SUM_W-1:0] res_sum;
  logic                            res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_row  <= i_idx;
      res_col  <= j_idx;
      res_sum  <= acc;
      res_last <= final_entry;
    end
  end

  assign res.valid   = res_valid;
  assign res.out_row = res_row;
  assign res.out_col = res_col;
  assign res.sum     = res_sum;
  assign res.last    = res_last;

  // A finished entry is only held while the walk waits for it or hands it
  // over to the output register.
  assert property (@(posedge clk) disable iff (rst)
    acc_done |-> (st == mm_pkg::ST_WAIT || st == mm_pkg::ST_EMIT))
    else $error("entry finished outside the wait and emit states");

  // Handing over the final entry ends the product.
  assert property (@(posedge clk) disable iff (rst)
    (emit && final_entry) |=> st == mm_pkg::ST_IDLE)
    else $error("walk did not end after the final entry");

  // Products only arrive while an entry is being summed.
  assert property (@(posedge clk) disable iff (rst)
    prod_v |-> (st == mm_pkg::ST_RUN || st == mm_pkg::ST_WAIT))
    else $error("product term outside an entry");

  // The term counter stays within the inner dimension during a walk.
  assert property (@(posedge clk) disable iff (rst)
    st == mm_pkg::ST_RUN |-> r_idx <= k_last)
    else $error("term index beyond inner dimension");

endmodule

`default_nettype wire
